>>> hdl/shift_register_io_scanner_macros.svh
// Assertion macros for the shift-register I/O scanner.
// No dependencies; included by the modules that carry assertions.
`ifndef SHIFT_REGISTER_IO_SCANNER_MACROS_SVH
`define SHIFT_REGISTER_IO_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define SRIO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SRIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SRIO_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SRIO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/srio_pkg.sv
// Shared types and constants for the shift-register I/O scanner.
// No dependencies.
package srio_pkg;

    localparam int IMAGE_BITS        = 32;
    localparam int INPUT_COUNT_DEF   = 32;
    localparam int OUTPUT_COUNT_DEF  = 32;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_SET_OUT  = 3'd2;
    localparam logic [2:0] ACT_READ_IN  = 3'd3;
    localparam logic [2:0] ACT_READ_OUT = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] bit_index;
        logic       bit_value;
        logic       serial_in;
    } cmd_item_t;

    typedef struct packed {
        logic load_pin;
        logic shift_pin;
        logic store_pin;
        logic data_pin;
        logic busy_res;
        logic read_bit;
        logic rejected;
    } rsp_item_t;

    typedef struct packed {
        logic       busy;
        logic       busy_next;
        logic       step_fire;
        logic [5:0] step_idx;
        logic       load_pin;
        logic       shift_pin;
        logic       store_pin;
    } seq_status_t;

endpackage

>>> hdl/srio_chan_if.sv
// Valid/ready channel carrying one transaction payload.
// Payload type is set per instance, normally from srio_pkg.
interface srio_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/srio_seq.sv
// Exchange sequencer: stage, pulse phase, bit and delay counters.
// Depends on srio_pkg and the scanner macro header.
`include "shift_register_io_scanner_macros.svh"

module srio_seq
    import srio_pkg::*;
#(
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_en,
    input  logic        start_en,
    input  logic [15:0] delay_ticks,
    output seq_status_t status
);

    localparam logic [1:0] STAGE_IDLE  = 2'd0;
    localparam logic [1:0] STAGE_LOAD  = 2'd1;
    localparam logic [1:0] STAGE_SHIFT = 2'd2;
    localparam logic [1:0] STAGE_STORE = 2'd3;

    localparam logic [1:0] PHASE_HIGH = 2'd1;
    localparam logic [1:0] PHASE_LAST = 2'd2;

    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  bc_reg, bc_next;
    logic [15:0] dc_reg, dc_next;
    logic [15:0] limit;
    logic [15:0] dc_inc;
    logic [6:0]  bc_inc;
    logic        fire;

    always_comb
    begin
        limit      = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
        dc_inc     = dc_reg + 16'd1;
        bc_inc     = {1'b0, bc_reg} + 7'd1;
        stage_next = stage_reg;
        phase_next = phase_reg;
        bc_next    = bc_reg;
        dc_next    = dc_reg;
        fire       = 1'b0;
        if (start_en)
        begin
            stage_next = STAGE_LOAD;
            phase_next = 2'd0;
            bc_next    = 6'd0;
            dc_next    = 16'd0;
        end
        else if (tick_en && stage_reg != STAGE_IDLE)
        begin
            if (dc_inc < limit)
            begin
                dc_next = dc_inc;
            end
            else
            begin
                dc_next = 16'd0;
                if (phase_reg != PHASE_LAST)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    phase_next = 2'd0;
                    case (stage_reg)
                        STAGE_LOAD:
                        begin
                            stage_next = STAGE_SHIFT;
                            bc_next    = 6'd0;
                            fire       = 1'b1;
                        end
                        STAGE_SHIFT:
                        begin
                            if (bc_inc < 7'(OUTPUT_COUNT))
                            begin
                                bc_next = bc_inc[5:0];
                                fire    = 1'b1;
                            end
                            else
                            begin
                                stage_next = STAGE_STORE;
                            end
                        end
                        STAGE_STORE:
                        begin
                            stage_next = STAGE_IDLE;
                            bc_next    = 6'd0;
                        end
                        default:
                        begin
                            stage_next = stage_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_IDLE;
            phase_reg <= 2'd0;
            bc_reg    <= 6'd0;
            dc_reg    <= 16'd0;
        end
        else
        begin
            stage_reg <= stage_next;
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            dc_reg    <= dc_next;
        end
    end

    always_comb
    begin
        status.busy      = (stage_reg != STAGE_IDLE);
        status.busy_next = (stage_next != STAGE_IDLE);
        status.step_fire = fire;
        status.step_idx  = bc_next;
        status.load_pin  = (stage_next == STAGE_LOAD)  && (phase_next == PHASE_HIGH);
        status.shift_pin = (stage_next == STAGE_SHIFT) && (phase_next == PHASE_HIGH);
        status.store_pin = (stage_next == STAGE_STORE) && (phase_next == PHASE_HIGH);
    end

    `SRIO_ASSERT_IMPL(a_idle_clear, clk, rst_n, stage_reg == STAGE_IDLE, phase_reg == 2'd0 && dc_reg == 16'd0)
    `SRIO_ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, phase_reg != 2'd3)
    `SRIO_ASSERT_NEXT(a_start_load, clk, rst_n, start_en, stage_reg == STAGE_LOAD && bc_reg == 6'd0)

endmodule

>>> hdl/shift_register_io_scanner.sv
// Shift-register I/O expander chain scanner, top level.
// Depends on srio_pkg, srio_chan_if, srio_seq and the scanner macro header.
//
// Usage:
//   cmd carries one transaction per item: tick, start exchange, set output bit,
//   read input bit or read output bit. rsp returns exactly one transaction per
//   cmd item, in order, with the pin levels after that item, busy, read data
//   and a reject flag. cfg_wr_en/cfg_wr_data write the delay (ticks per pulse
//   phase, zero acts as one); write it only while no exchange runs.
//   Response: registered, valid in the cycle after its command is taken.
//   Throughput: one command per cycle while rsp takes responses; each item is
//   a counter step and a bit update done between the state registers and the
//   response register. If rsp stalls, the response register holds and
//   cmd.ready drops until the response is taken; cmd.ready is high whenever
//   the register is empty or being drained in the same cycle.
//   Reset: images, sequencer and delay counter clear, delay becomes 1, the
//   response register empties.
`include "shift_register_io_scanner_macros.svh"

module shift_register_io_scanner
    import srio_pkg::*;
#(
    parameter int INPUT_COUNT  = INPUT_COUNT_DEF,
    parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    srio_chan_if.sink   cmd,
    srio_chan_if.source rsp,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IMG_IN_W  = (INPUT_COUNT  < IMAGE_BITS) ? INPUT_COUNT  : IMAGE_BITS;
    localparam int IMG_OUT_W = (OUTPUT_COUNT < IMAGE_BITS) ? OUTPUT_COUNT : IMAGE_BITS;

    logic [15:0]          delay_reg;
    logic [IMG_IN_W-1:0]  in_img_reg, in_img_next;
    logic [IMG_OUT_W-1:0] out_img_reg, out_img_next;
    logic                 data_reg, data_next;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_reg, rsp_next;

    logic                 accept;
    logic                 tick_en;
    logic                 start_en;
    seq_status_t          seq_st;
    cmd_item_t            c;
    logic [5:0]           idx_ext;
    logic                 in_range_in;
    logic                 in_range_out;
    logic [IMG_IN_W-1:0]  rd_in_shift;
    logic [IMG_OUT_W-1:0] rd_out_shift;
    logic [IMG_IN_W-1:0]  step_mask;
    logic [IMG_OUT_W-1:0] step_shift;
    logic [IMG_OUT_W-1:0] set_mask;
    logic                 rd;
    logic                 rej;

    assign c         = cmd.data;
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign tick_en   = accept && (c.action == ACT_TICK);
    assign start_en  = accept && (c.action == ACT_START) && !seq_st.busy;

    srio_seq #(
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .start_en    (start_en),
        .delay_ticks (delay_reg),
        .status      (seq_st)
    );

    always_comb
    begin
        idx_ext      = {1'b0, c.bit_index};
        in_range_in  = idx_ext < 6'(IMG_IN_W);
        in_range_out = idx_ext < 6'(IMG_OUT_W);
        rd_in_shift  = in_img_reg >> c.bit_index;
        rd_out_shift = out_img_reg >> c.bit_index;
        step_mask    = IMG_IN_W'(1) << seq_st.step_idx;
        step_shift   = out_img_reg >> seq_st.step_idx;
        set_mask     = IMG_OUT_W'(1) << c.bit_index;

        in_img_next  = in_img_reg;
        out_img_next = out_img_reg;
        data_next    = data_reg;
        rd           = 1'b0;
        rej          = 1'b0;

        if (seq_st.step_fire)
        begin
            in_img_next = c.serial_in ? (in_img_reg | step_mask) : (in_img_reg & ~step_mask);
            data_next   = step_shift[0];
        end

        case (c.action)
            ACT_TICK:
            begin
                rej = 1'b0;
            end
            ACT_START:
            begin
                rej = seq_st.busy;
            end
            ACT_SET_OUT:
            begin
                if (seq_st.busy || !in_range_out)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    out_img_next = c.bit_value ? (out_img_reg | set_mask)
                                               : (out_img_reg & ~set_mask);
                end
            end
            ACT_READ_IN:
            begin
                rej = !in_range_in;
                rd  = in_range_in && rd_in_shift[0];
            end
            ACT_READ_OUT:
            begin
                rej = !in_range_out;
                rd  = in_range_out && rd_out_shift[0];
            end
            default:
            begin
                rej = 1'b1;
            end
        endcase

        rsp_next.load_pin  = seq_st.load_pin;
        rsp_next.shift_pin = seq_st.shift_pin;
        rsp_next.store_pin = seq_st.store_pin;
        rsp_next.data_pin  = data_next;
        rsp_next.busy_res  = seq_st.busy_next;
        rsp_next.read_bit  = rd;
        rsp_next.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= 16'd1;
            in_img_reg    <= '0;
            out_img_reg   <= '0;
            data_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delay_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                in_img_reg    <= in_img_next;
                out_img_reg   <= out_img_next;
                data_reg      <= data_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    `SRIO_ASSERT_NEXT(a_accept_gives_rsp, clk, rst_n, accept, rsp_valid_reg)
    `SRIO_ASSERT_IMPL(a_pins_exclusive, clk, rst_n, rsp_valid_reg, $onehot0({rsp_reg.load_pin, rsp_reg.shift_pin, rsp_reg.store_pin}))
    `SRIO_ASSERT_IMPL(a_pin_needs_busy, clk, rst_n, rsp_valid_reg && (rsp_reg.load_pin || rsp_reg.shift_pin || rsp_reg.store_pin), rsp_reg.busy_res)

endmodule

>>> tb/sv/tb_shift_register_io_scanner.sv
// Self-checking testbench for shift_register_io_scanner: directed table, then random
// phases over several pulse delays, responses checked against table or in-bench model.
// Depends on srio_pkg, srio_chan_if and the scanner RTL.
module tb_shift_register_io_scanner;
    import srio_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_IN        = INPUT_COUNT_DEF;
    localparam int N_OUT       = OUTPUT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int PHASE_ITEMS = 60;
    localparam int LONG_ITEMS  = 40;
    localparam int MAX_PRINTS  = 40;

    localparam logic [2:0] ACT_RSVD_5 = 3'd5;
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    // response bits: load, shift, store, data, busy, read, rejected
    localparam rsp_item_t R_QUIET      = 7'b0000000;
    localparam rsp_item_t R_REJ        = 7'b0000001;
    localparam rsp_item_t R_READ1      = 7'b0000010;
    localparam rsp_item_t R_BUSY       = 7'b0000100;
    localparam rsp_item_t R_BUSY_REJ   = 7'b0000101;
    localparam rsp_item_t R_BUSY_READ1 = 7'b0000110;

    typedef enum logic [1:0] {XCH_IDLE, XCH_LOAD, XCH_SHIFT, XCH_STORE} xch_stage_t;

    typedef struct packed {
        cmd_item_t cmd;
        logic      fixed;
        rsp_item_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [25] = '{
        {ACT_READ_IN,  5'd0,  1'b0, 1'b0, 1'b1, R_QUIET},
        {ACT_READ_IN,  5'd31, 1'b1, 1'b1, 1'b1, R_QUIET},
        {ACT_READ_OUT, 5'd0,  1'b0, 1'b0, 1'b1, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b1, 1'b1, R_QUIET},
        {ACT_RSVD_5,   5'd0,  1'b0, 1'b0, 1'b1, R_REJ},
        {ACT_RSVD_6,   5'd31, 1'b1, 1'b1, 1'b1, R_REJ},
        {ACT_RSVD_7,   5'd31, 1'b1, 1'b1, 1'b1, R_REJ},
        {ACT_SET_OUT,  5'd0,  1'b1, 1'b0, 1'b1, R_QUIET},
        {ACT_SET_OUT,  5'd31, 1'b1, 1'b1, 1'b1, R_QUIET},
        {ACT_SET_OUT,  5'd15, 1'b1, 1'b0, 1'b1, R_QUIET},
        {ACT_SET_OUT,  5'd15, 1'b0, 1'b0, 1'b1, R_QUIET},
        {ACT_READ_OUT, 5'd31, 1'b0, 1'b0, 1'b1, R_READ1},
        {ACT_READ_OUT, 5'd15, 1'b0, 1'b0, 1'b1, R_QUIET},
        {ACT_START,    5'd0,  1'b0, 1'b0, 1'b1, R_BUSY},
        {ACT_START,    5'd0,  1'b0, 1'b0, 1'b1, R_BUSY_REJ},
        {ACT_SET_OUT,  5'd1,  1'b1, 1'b0, 1'b1, R_BUSY_REJ},
        {ACT_READ_OUT, 5'd0,  1'b0, 1'b0, 1'b1, R_BUSY_READ1},
        {ACT_TICK,     5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b1, 1'b0, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_READ_IN,  5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_TICK,     5'd0,  1'b0, 1'b0, 1'b0, R_QUIET},
        {ACT_READ_IN,  5'd31, 1'b0, 1'b0, 1'b0, R_QUIET}
    };

    localparam logic [15:0] PHASE_DELAY [5] = '{16'd0, 16'd2, 16'd1, 16'd3, 16'd1};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    srio_chan_if #(.payload_t(cmd_item_t)) cmd_ch ();
    srio_chan_if #(.payload_t(rsp_item_t)) rsp_ch ();

    shift_register_io_scanner #(
        .INPUT_COUNT  (N_IN),
        .OUTPUT_COUNT (N_OUT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // scanner model state
    logic [31:0] in_img;
    logic [31:0] out_img;
    xch_stage_t  xch;
    logic [1:0]  phase;
    logic [5:0]  bit_ctr;
    logic [15:0] tick_ctr;
    logic        data_lvl;
    logic [15:0] delay_cfg;

    rsp_item_t   scan_rsp_q [$];
    logic        fixed_pend;
    rsp_item_t   fixed_want;
    bit          src_gaps;
    bit          sink_stalls;
    int          mismatches;
    int          rsp_seen;
    int          exchanges;
    int          rejects;
    int          cycles;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] response %0d: %s", $realtime, rsp_seen, msg);
    endtask

    task automatic compare_rsp(input rsp_item_t got, input rsp_item_t want);
        if (got.load_pin !== want.load_pin)
            report_mismatch($sformatf("load_pin %b want %b", got.load_pin, want.load_pin));
        if (got.shift_pin !== want.shift_pin)
            report_mismatch($sformatf("shift_pin %b want %b", got.shift_pin, want.shift_pin));
        if (got.store_pin !== want.store_pin)
            report_mismatch($sformatf("store_pin %b want %b", got.store_pin, want.store_pin));
        if (got.data_pin !== want.data_pin)
            report_mismatch($sformatf("data_pin %b want %b", got.data_pin, want.data_pin));
        if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res %b want %b", got.busy_res, want.busy_res));
        if (got.read_bit !== want.read_bit)
            report_mismatch($sformatf("read_bit %b want %b", got.read_bit, want.read_bit));
        if (got.rejected !== want.rejected)
            report_mismatch($sformatf("rejected %b want %b", got.rejected, want.rejected));
    endtask

    function automatic void latch_step(input logic serial);
        if (bit_ctr < N_IN && bit_ctr < IMAGE_BITS)
            in_img[bit_ctr[4:0]] = serial;
        data_lvl = (bit_ctr < IMAGE_BITS) ? out_img[bit_ctr[4:0]] : 1'b0;
    endfunction

    function automatic void advance_tick(input logic serial);
        logic [15:0] lim;
        lim = (delay_cfg == 16'd0) ? 16'd1 : delay_cfg;
        if (xch == XCH_IDLE)
            return;
        tick_ctr = tick_ctr + 16'd1;
        if (tick_ctr < lim)
            return;
        tick_ctr = '0;
        phase = phase + 2'd1;
        if (phase < 2'd3)
            return;
        phase = '0;
        case (xch)
            XCH_LOAD:
            begin
                xch = XCH_SHIFT;
                bit_ctr = '0;
                latch_step(serial);
            end
            XCH_SHIFT:
            begin
                if (int'(bit_ctr) + 1 < N_OUT)
                begin
                    bit_ctr = bit_ctr + 6'd1;
                    latch_step(serial);
                end
                else
                    xch = XCH_STORE;
            end
            default:
            begin
                xch = XCH_IDLE;
                bit_ctr = '0;
            end
        endcase
    endfunction

    function automatic rsp_item_t scanner_step(input cmd_item_t c);
        rsp_item_t r;
        logic      was_busy;
        r = '0;
        was_busy = (xch != XCH_IDLE);
        case (c.action)
            ACT_TICK:
                advance_tick(c.serial_in);
            ACT_START:
            begin
                if (was_busy)
                    r.rejected = 1'b1;
                else
                begin
                    xch = XCH_LOAD;
                    phase = '0;
                    bit_ctr = '0;
                    tick_ctr = '0;
                end
            end
            ACT_SET_OUT:
            begin
                if (was_busy || c.bit_index >= N_OUT)
                    r.rejected = 1'b1;
                else
                    out_img[c.bit_index] = c.bit_value;
            end
            ACT_READ_IN:
            begin
                if (c.bit_index >= N_IN)
                    r.rejected = 1'b1;
                else
                    r.read_bit = in_img[c.bit_index];
            end
            ACT_READ_OUT:
            begin
                if (c.bit_index >= N_OUT)
                    r.rejected = 1'b1;
                else
                    r.read_bit = out_img[c.bit_index];
            end
            default:
                r.rejected = 1'b1;
        endcase
        r.load_pin  = (xch == XCH_LOAD) && (phase == 2'd1);
        r.shift_pin = (xch == XCH_SHIFT) && (phase == 2'd1);
        r.store_pin = (xch == XCH_STORE) && (phase == 2'd1);
        r.data_pin  = data_lvl;
        r.busy_res  = (xch != XCH_IDLE);
        return r;
    endfunction

    // response check first, so a same-cycle response can never match its own command
    always @(posedge clk)
    begin : scan_monitor
        rsp_item_t pred;
        if (rst_n)
        begin
            if (cfg_wr_en)
                delay_cfg = cfg_wr_data;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (scan_rsp_q.size() == 0)
                    report_mismatch("transaction with nothing pending");
                else
                    compare_rsp(rsp_ch.data, scan_rsp_q.pop_front());
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                pred = scanner_step(cmd_ch.data);
                scan_rsp_q.push_back(fixed_pend ? fixed_want : pred);
                if (cmd_ch.data.action == ACT_START && !pred.rejected)
                    exchanges++;
                if (pred.rejected)
                    rejects++;
            end
        end
    end

    initial
    begin : rsp_sink
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int        pick;
        c.bit_index = 5'($urandom_range(0, 31));
        c.bit_value = 1'($urandom_range(0, 1));
        c.serial_in = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            c.action = ACT_TICK;
        else if (pick < 72)
            c.action = ACT_SET_OUT;
        else if (pick < 80)
            c.action = ACT_READ_IN;
        else if (pick < 88)
            c.action = ACT_READ_OUT;
        else if (pick < 96)
            c.action = ACT_START;
        else
            c.action = 3'($urandom_range(int'(ACT_RSVD_5), int'(ACT_RSVD_7)));
        return c;
    endfunction

    // returns at the clock edge where the transaction is taken
    task automatic send_cmd(input cmd_item_t c, input logic fixed, input rsp_item_t want);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        fixed_pend   <= fixed;
        fixed_want   <= want;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (scan_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // let any running exchange finish so the delay can be rewritten
    task automatic settle();
        cmd_item_t c;
        drain();
        while (xch != XCH_IDLE)
        begin
            repeat (32)
            begin
                c = random_cmd();
                c.action = ACT_TICK;
                send_cmd(c, 1'b0, R_QUIET);
            end
            drain();
        end
    endtask

    task automatic write_delay(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        cmd_item_t c;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        fixed_pend  = 1'b0;
        fixed_want  = '0;
        in_img      = '0;
        out_img     = '0;
        xch         = XCH_IDLE;
        phase       = '0;
        bit_ctr     = '0;
        tick_ctr    = '0;
        data_lvl    = 1'b0;
        delay_cfg   = 16'd1;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        mismatches  = 0;
        rsp_seen    = 0;
        exchanges   = 0;
        rejects     = 0;
        cycles      = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_cmd(DIRECTED[i].cmd, DIRECTED[i].fixed, DIRECTED[i].want);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_delay(PHASE_DELAY[p]);
            src_gaps    = (p == 0 || p == 1 || p == 3);
            sink_stalls = (p == 0 || p == 2 || p == 3);
            repeat (PHASE_ITEMS)
                send_cmd(random_cmd(), 1'b0, R_QUIET);
        end

        // longest delay: start one exchange and stay in the first low phase of the load
        settle();
        write_delay(16'hFFFF);
        c = random_cmd();
        c.action = ACT_START;
        send_cmd(c, 1'b0, R_QUIET);
        repeat (LONG_ITEMS)
        begin
            c = random_cmd();
            if ($urandom_range(0, 31) != 0)
                c.action = ACT_TICK;
            send_cmd(c, 1'b0, R_QUIET);
        end

        drain();
        repeat (4) @(posedge clk);

        $display("checked %0d responses: %0d exchanges started, %0d items rejected",
                 rsp_seen, exchanges, rejects);
        $display("pulse delays exercised: 0, 1, 2, 3 and 65535 ticks; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> shift_register_io_scanner.f
+incdir+hdl
hdl/srio_pkg.sv
hdl/srio_chan_if.sv
hdl/srio_seq.sv
hdl/shift_register_io_scanner.sv
tb/sv/tb_shift_register_io_scanner.sv
